/* design/bfdh_pkg.sv */
// Shared types and constants for the double-hash Bloom filter.
// Holds the controller/datapath command and status structs.
// No dependencies.
package bfdh_pkg;

  // Fixed field widths
  localparam int FB_W  = 15;
  localparam int KEY_W = 32;

  // Reset size of the filter in bytes
  localparam logic [FB_W-1:0] FB_RESET = 15'd16384;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // Remainder unit: 34-bit dividend, two quotient bits per cycle
  localparam int DVD_W      = 34;
  localparam int DIV_STEPS  = DVD_W / 2;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DVD_W-1:0] WRAP_DVD = 34'h1_0000_0000;

  // Dividend source / remainder destination
  typedef logic [1:0] div_src_t;
  localparam div_src_t DIV_KEY  = 2'd0;
  localparam div_src_t DIV_STEP = 2'd1;
  localparam div_src_t DIV_WRAP = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic     clr_wr;
    logic     load;
    logic     div_load;
    div_src_t load_src;
    logic     div_step;
    logic     div_save;
    div_src_t save_dst;
    logic     mem_rd;
    logic     mem_wr;
    logic     adv_add;
    logic     adv_wrap;
    logic     emit;
    logic     emit_val;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic bit_set;
    logic is_find;
    logic last_probe;
    logic out_full;
  } status_t;

endpackage

/* design/bfdh_datapath.sv */
// Datapath of the Bloom filter: size register, remainder unit, probe
// position tracking, byte-wide bit store and result register.
// Depends on bfdh_pkg.
module bfdh_datapath #(
  parameter int MAX_BYTES = 16384,
  parameter int PROBES    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bfdh_pkg::FB_W-1:0]   cfg_wr_data,
  input  logic                        op,
  input  logic [bfdh_pkg::KEY_W-1:0]  key_hash,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        present,
  input  bfdh_pkg::cmd_t              cmd,
  output bfdh_pkg::status_t           status
);
  import bfdh_pkg::*;

  localparam int AW   = $clog2(MAX_BYTES);
  localparam int SW   = AW + 4;
  localparam int PCW  = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int CMPW = (FB_W > AW + 1) ? FB_W : AW + 1;

  logic [FB_W-1:0]      filter_bytes;
  logic                 op_reg;
  logic [KEY_W-1:0]     h_run;
  logic [KEY_W-1:0]     step;
  logic                 carry;
  logic [SW-1:0]        size_bits;
  logic [SW-1:0]        pos;
  logic [SW-1:0]        step_mod;
  logic [SW-1:0]        wrap_mod;
  logic [DVD_W-1:0]     dvd;
  logic [SW-1:0]        rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PCW-1:0]       probe_cnt;
  logic [AW-1:0]        clr_addr;
  logic [7:0]           mem [MAX_BYTES];
  logic [7:0]           rdata;

  logic [CMPW-1:0]      fb_w;
  logic [CMPW-1:0]      eff_w;
  logic [SW-1:0]        size_now;
  logic [SW:0]          r1;
  logic [SW:0]          r1s;
  logic [SW:0]          r2;
  logic [SW:0]          r2s;
  logic [SW-1:0]        rem_next;
  logic [KEY_W:0]       h_sum;
  logic [SW:0]          pos_sum;
  logic [SW:0]          pos_red;
  logic [SW-1:0]        pos_wrap;
  logic [AW-1:0]        byte_addr;
  logic [7:0]           bit_mask;

  // Size register, written at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bytes <= FB_RESET;
    end else if (cfg_wr_en) begin
      filter_bytes <= cfg_wr_data;
    end
  end

  // Effective size in bits: zero reads as one byte, clamp to the store
  always_comb begin
    fb_w = CMPW'(filter_bytes);
    if (fb_w == '0) begin
      eff_w = CMPW'(1);
    end else if (fb_w > CMPW'(MAX_BYTES)) begin
      eff_w = CMPW'(MAX_BYTES);
    end else begin
      eff_w = fb_w;
    end
    size_now = {eff_w[AW:0], 3'b000};
  end

  // Remainder unit: two restoring steps per cycle
  always_comb begin
    r1       = {rem, dvd[DVD_W-1]};
    r1s      = (r1 >= {1'b0, size_bits}) ? r1 - {1'b0, size_bits} : r1;
    r2       = {r1s[SW-1:0], dvd[DVD_W-2]};
    r2s      = (r2 >= {1'b0, size_bits}) ? r2 - {1'b0, size_bits} : r2;
    rem_next = r2s[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      case (cmd.load_src)
        DIV_KEY:  dvd <= {2'b00, key_hash};
        DIV_STEP: dvd <= {2'b00, step};
        DIV_WRAP: dvd <= WRAP_DVD;
        default:  dvd <= '0;
      endcase
    end else if (cmd.div_step) begin
      rem <= rem_next;
      dvd <= {dvd[DVD_W-3:0], 2'b00};
    end
  end

  // Probe position arithmetic
  always_comb begin
    h_sum    = {1'b0, h_run} + {1'b0, step};
    pos_sum  = {1'b0, pos} + {1'b0, step_mod};
    pos_red  = (pos_sum >= {1'b0, size_bits}) ? pos_sum - {1'b0, size_bits} : pos_sum;
    pos_wrap = (pos >= wrap_mod) ? pos - wrap_mod : pos + (size_bits - wrap_mod);
  end

  // Item registers and running position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg    <= op;
      h_run     <= key_hash;
      step      <= {key_hash[16:0], key_hash[31:17]};
      size_bits <= size_now;
      carry     <= 1'b0;
    end else if (cmd.adv_add) begin
      h_run <= h_sum[KEY_W-1:0];
      carry <= h_sum[KEY_W];
    end
    if (cmd.div_save) begin
      case (cmd.save_dst)
        DIV_KEY:  pos      <= rem_next;
        DIV_STEP: step_mod <= rem_next;
        DIV_WRAP: wrap_mod <= rem_next;
        default:  pos      <= pos;
      endcase
    end else if (cmd.adv_add) begin
      pos <= pos_red[SW-1:0];
    end else if (cmd.adv_wrap && carry) begin
      pos <= pos_wrap;
    end
  end

  // Probe counter
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_cnt <= '0;
    end else if (cmd.load) begin
      probe_cnt <= '0;
    end else if (cmd.adv_wrap) begin
      probe_cnt <= probe_cnt + PCW'(1);
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign byte_addr = pos[AW+2:3];
  assign bit_mask  = 8'b0000_0001 << pos[2:0];

  // Bit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= 8'h00;
    end else if (cmd.mem_wr) begin
      mem[byte_addr] <= rdata | bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata <= mem[byte_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      present <= cmd.emit_val;
    end
  end

  // Status
  always_comb begin
    status.clr_last   = (clr_addr == AW'(MAX_BYTES - 1));
    status.div_last   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    status.bit_set    = rdata[pos[2:0]];
    status.is_find    = (op_reg == OP_FIND);
    status.last_probe = (probe_cnt == PCW'(PROBES - 1));
    status.out_full   = out_valid && out_stall;
  end

endmodule

/* design/bfdh_ctrl.sv */
// Controller of the Bloom filter: sequences the clearing sweep, the three
// remainder computations and the per-probe read / check / advance steps.
// Depends on bfdh_pkg.
module bfdh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bfdh_pkg::status_t status,
  output bfdh_pkg::cmd_t    cmd
);
  import bfdh_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DIV_KEY  = 4'd2;
  localparam logic [3:0] S_DIV_STEP = 4'd3;
  localparam logic [3:0] S_DIV_WRAP = 4'd4;
  localparam logic [3:0] S_READ     = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_ADV      = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       found;
  logic       found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.div_load = 1'b1;
          cmd.load_src = DIV_KEY;
          state_next   = S_DIV_KEY;
        end
      end
      S_DIV_KEY: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.div_save = 1'b1;
          cmd.save_dst = DIV_KEY;
          cmd.div_load = 1'b1;
          cmd.load_src = DIV_STEP;
          state_next   = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.div_save = 1'b1;
          cmd.save_dst = DIV_STEP;
          cmd.div_load = 1'b1;
          cmd.load_src = DIV_WRAP;
          state_next   = S_DIV_WRAP;
        end
      end
      S_DIV_WRAP: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.div_save = 1'b1;
          cmd.save_dst = DIV_WRAP;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.is_find && !status.bit_set) begin
          // clear bit: definitely absent, stop probing
          found_next = 1'b0;
          state_next = S_EMIT;
        end else begin
          cmd.mem_wr = !status.is_find;
          if (status.last_probe) begin
            found_next = 1'b1;
            state_next = status.is_find ? S_EMIT : S_IDLE;
          end else begin
            cmd.adv_add = 1'b1;
            state_next  = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.adv_wrap = 1'b1;
        state_next   = S_READ;
      end
      S_EMIT: begin
        if (!status.out_full) begin
          cmd.emit     = 1'b1;
          cmd.emit_val = found;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/bloom_filter_double_hash.sv */
// Top level of the double-hash Bloom filter.
// Instantiates bfdh_ctrl and bfdh_datapath; depends on bfdh_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, op, key_hash): op 0 adds the key,
//   op 1 queries it. Output channel (out_valid / out_stall, present): one
//   response per query, none for an add. A request is taken when valid is
//   high and stall is low.
//   Sequence: remainder work after the accept edge (key, step and
//   2^32 modulo the size, two bits per cycle in the shared remainder
//   unit), then read and check/update for each probe with a position
//   advance between probes. An add holds the block until its last
//   probe is written. A query that checks all eight bits holds the
//   block until its response is loaded into the output register; it
//   stops early at its first clear bit.
//   Reset: synchronous rst restores filter_bytes to 16384 and starts a
//   clearing pass that zeroes all MAX_BYTES bytes of the bit store;
//   in_stall stays high until it ends. cfg writes are taken at any time.
//   Receiver stall: the response waits in the output register; the next
//   request is still accepted and processed, and only a second response
//   waits until the first one is taken.
module bloom_filter_double_hash #(
  parameter int MAX_BYTES = 16384,
  parameter int PROBES    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bfdh_pkg::FB_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [bfdh_pkg::KEY_W-1:0]  key_hash,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        present
);
  import bfdh_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, bit store and result register
  bfdh_datapath #(
    .MAX_BYTES (MAX_BYTES),
    .PROBES    (PROBES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (op),
    .key_hash    (key_hash),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .present     (present),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
